// File: hw/rtl/gfeca_pkg.sv
`timescale 1ns / 1ps

package gfeca_pkg;

  // Field widths
  localparam int DATA_W = 16;
  localparam int COEF_W = 16;
  localparam int POS_W  = 10;
  localparam int BYTE_W = 8;

  // Stream and config bus widths
  localparam int S_TDATA_W   = 48;  // data_word, coefficient, word_position, pad
  localparam int M_TDATA_W   = 32;  // coding_word, out_position, pad
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  // Config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLY_W8   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLY_W16  = 2'd2;

  // Reset values; only the bits below the top bit of each polynomial matter
  localparam logic [BYTE_W-1:0] POLY_W8_RST  = 8'h1D;
  localparam logic [DATA_W-1:0] POLY_W16_RST = 16'h100B;

  // Fixed-point shift of the reciprocal used to fold word_position into the store
  localparam int RECIP_SHIFT = 20;

  // Partial state of a shift-and-add GF(2^16) product
  typedef struct packed {
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] a;
  } gf_part_t;

endpackage

// File: hw/rtl/gf_erasure_code_accumulator.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake      | Payload (low bit first)
// s_axis  | in  | tvalid, tready | tdata: data, coef, position; tuser: first; tlast: last
// m_axis  | out | tvalid, tready | tdata: coding_word, out_position
// cfg     | in  | valid, ready   | cfg_index, cfg_data
//
// One item per cycle unless the output stalls: each item does one registered read and one write
// of the store. Between the input transfer and m_axis_tvalid lie stage 1, stage 2 and the output.
// A read of the entry written in the same cycle takes the forwarded write value.
// Reset (rst, synchronous) clears the pipeline and config registers; the store is not swept.
// An emitting item waits in stage 2 while the output register holds a stalled transfer,
// and everything behind it waits too; non-emitting items retire without waiting.

module gf_erasure_code_accumulator #(
  parameter int BLOCK_WORDS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: [15:0] data_word, [31:16] coefficient, [41:32] word_position, [47:42] zero
  input  logic [gfeca_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser: [0] first_source
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [15:0] coding_word, [25:16] out_position, [31:26] zero
  output logic [gfeca_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gfeca_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gfeca_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DATA_W  = gfeca_pkg::DATA_W;
  localparam int BYTE_W  = gfeca_pkg::BYTE_W;
  localparam int POS_W   = gfeca_pkg::POS_W;
  localparam int IDX_W   = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int RECIP_W = gfeca_pkg::RECIP_SHIFT + 1;
  localparam int QP_W    = POS_W + RECIP_W;
  localparam int M_PAD   = gfeca_pkg::M_TDATA_W - DATA_W - POS_W;
  // ceil(2^shift / BLOCK_WORDS): exact quotient for every 10-bit position
  localparam longint unsigned RECIP =
    ((64'd1 << gfeca_pkg::RECIP_SHIFT) + 64'(BLOCK_WORDS) - 64'd1) / 64'(BLOCK_WORDS);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  // Remainder is below 1024, so only the low bits of the depth matter
  localparam logic [POS_W-1:0]   BW_LO   = POS_W'(BLOCK_WORDS);

  // GF(2^8) multiply, poly holds the bits below x^8
  function automatic logic [BYTE_W-1:0] gf8_mul(input logic [BYTE_W-1:0] a_in,
                                                input logic [BYTE_W-1:0] b_in,
                                                input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] acc;
    logic              carry;
    a   = a_in;
    acc = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b_in[k]) acc ^= a;
      carry = a[BYTE_W-1];
      a     = {a[BYTE_W-2:0], 1'b0};
      if (carry) a ^= poly;
    end
    return acc;
  endfunction

  // Eight shift-and-add steps of a GF(2^16) multiply
  function automatic gfeca_pkg::gf_part_t gf16_half(input gfeca_pkg::gf_part_t st,
                                                   input logic [BYTE_W-1:0] b_in,
                                                   input logic [DATA_W-1:0] poly);
    gfeca_pkg::gf_part_t r;
    logic                carry;
    r = st;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b_in[k]) r.acc ^= r.a;
      carry = r.a[DATA_W-1];
      r.a   = {r.a[DATA_W-2:0], 1'b0};
      if (carry) r.a ^= poly;
    end
    return r;
  endfunction

  // Config registers
  logic              word_mode;
  logic [BYTE_W-1:0] poly_w8;
  logic [DATA_W-1:0] poly_w16;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode <= 1'b0;
      poly_w8   <= gfeca_pkg::POLY_W8_RST;
      poly_w16  <= gfeca_pkg::POLY_W16_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gfeca_pkg::CFG_WORD_MODE: word_mode <= cfg_data[0];
        gfeca_pkg::CFG_POLY_W8:   poly_w8   <= cfg_data[BYTE_W-1:0];
        gfeca_pkg::CFG_POLY_W16:  poly_w16  <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Input field unpack
  logic [DATA_W-1:0] in_data;
  logic [DATA_W-1:0] in_coef;
  logic [POS_W-1:0]  in_pos;

  assign in_data = s_axis_tdata[DATA_W-1:0];
  assign in_coef = s_axis_tdata[DATA_W +: gfeca_pkg::COEF_W];
  assign in_pos  = s_axis_tdata[DATA_W + gfeca_pkg::COEF_W +: POS_W];

  // Handshake chain: stage 1 -> stage 2 (store read) -> output register
  logic r1_valid, r2_valid, o_valid;
  logic r1_fire, r2_fire, s_xfer;
  logic r2_last;

  assign r2_fire       = r2_valid && (!r2_last || !o_valid || m_axis_tready);
  assign r1_fire       = r1_valid && (!r2_valid || r2_fire);
  assign s_axis_tready = !rst && (!r1_valid || r1_fire);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      r1_valid <= s_xfer || (r1_valid && !r1_fire);
      r2_valid <= r1_fire || (r2_valid && !r2_fire);
      o_valid  <= (r2_fire && r2_last) || (o_valid && !m_axis_tready);
    end
  end

  // Stage 1: byte-lane products (8-bit mode) or low half of the 16-bit product,
  // plus the quotient estimate for the store index.
  gfeca_pkg::gf_part_t part16, r1_part_next, r1_part;
  logic [BYTE_W-1:0]   lo8, hi8;
  logic [QP_W-1:0]     q_prod;
  logic [BYTE_W-1:0]   r1_b;
  logic [POS_W-1:0]    r1_pos, r1_q;
  logic                r1_first, r1_last;

  assign lo8    = gf8_mul(in_data[BYTE_W-1:0], in_coef[BYTE_W-1:0], poly_w8);
  assign hi8    = gf8_mul(in_data[DATA_W-1:BYTE_W], in_coef[BYTE_W-1:0], poly_w8);
  assign part16 = gf16_half('{acc: '0, a: in_data}, in_coef[BYTE_W-1:0], poly_w16);
  assign q_prod = QP_W'(in_pos) * QP_W'(RECIP_C);

  always_comb begin
    if (word_mode) begin
      r1_part_next = part16;
    end else begin
      r1_part_next.acc = {hi8, lo8};
      r1_part_next.a   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      r1_part  <= r1_part_next;
      // in 8-bit mode the product is done; zero multiplier bits pass it through
      r1_b     <= word_mode ? in_coef[DATA_W-1:BYTE_W] : '0;
      r1_pos   <= in_pos;
      r1_q     <= q_prod[gfeca_pkg::RECIP_SHIFT +: POS_W];
      r1_first <= s_axis_tuser;
      r1_last  <= s_axis_tlast;
    end
  end

  // Stage 1 -> 2: finish the product, fold position into the store, read it
  gfeca_pkg::gf_part_t part_hi;
  logic [POS_W-1:0]    qb;
  logic [IDX_W-1:0]    rd_idx;

  assign part_hi = gf16_half(r1_part, r1_b, poly_w16);
  assign qb      = POS_W'(r1_q * BW_LO);
  assign rd_idx  = IDX_W'(r1_pos - qb);

  logic [DATA_W-1:0] r2_prod, r2_fwd_val, rd_data, base, val;
  logic [IDX_W-1:0]  r2_idx;
  logic [POS_W-1:0]  r2_pos;
  logic              r2_first, r2_fwd_hit;

  assign base = r2_fwd_hit ? r2_fwd_val : rd_data;
  assign val  = r2_first ? r2_prod : (base ^ r2_prod);

  always_ff @(posedge clk) begin
    if (r1_fire) begin
      r2_prod    <= part_hi.acc;
      r2_idx     <= rd_idx;
      r2_pos     <= r1_pos;
      r2_first   <= r1_first;
      r2_last    <= r1_last;
      // stage 2 writes the same entry at this edge; the read would be stale
      r2_fwd_hit <= r2_fire && (r2_idx == rd_idx);
      r2_fwd_val <= val;
    end
  end

  // Coding store: registered read, write at retire
  logic [DATA_W-1:0] coding_store [BLOCK_WORDS];

  always_ff @(posedge clk) begin
    if (r2_fire) coding_store[r2_idx] <= val;
    if (r1_fire) rd_data <= coding_store[rd_idx];
  end

  // Output register
  logic [DATA_W-1:0] o_word;
  logic [POS_W-1:0]  o_pos;

  always_ff @(posedge clk) begin
    if (r2_fire && r2_last) begin
      o_word <= val;
      o_pos  <= r2_pos;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {{M_PAD{1'b0}}, o_pos, o_word};

endmodule

// File: hw/rtl/gfeca_check.sv
`timescale 1ns / 1ps

module gfeca_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gfeca_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic last_xfer;
  assign last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  // stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("m_axis result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("m_axis valid after reset");

  // an emitting item reaches the output via stage 1 and stage 2 when the sink keeps up
  a_emit_latency: assert property (@(posedge clk) disable iff (rst)
    last_xfer ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("emitting transfer did not reach m_axis");

  // no result appears without a recent emitting transfer once the pipe drains
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!last_xfer && m_axis_tready) ##1 (!last_xfer && m_axis_tready) ##1 m_axis_tready
    |=> !m_axis_tvalid)
    else $error("m_axis result without an emitting transfer");

endmodule

bind gf_erasure_code_accumulator gfeca_check u_gfeca_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
